// ----- hw/rtl/swseq_pkg.sv -----
// ============================================================================
// swseq_pkg
// Shared types, widths, codes and the path table of the slope waypoint
// sequencer.
// ============================================================================
package swseq_pkg;

  localparam int PITCH_W  = 17;   // Q.8 degrees, signed
  localparam int ANGLE_W  = 18;   // heading target and awaited pitch width
  localparam int DWELL_W  = 16;
  localparam int TICK_W   = 8;
  localparam int CFG_W    = 17;   // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int STEP_OUT_W = 3;

  localparam int WINDOW_LEN_DEF = 8;
  localparam int PATH_STEPS_DEF = 7;
  localparam int ROM_ROWS       = 7;
  localparam int ONE_DEG        = 256;

  localparam logic [DWELL_W-1:0] DWELL_LIMIT_RST = 16'd1000;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [PITCH_W-1:0] pitch_t;

  // Request codes.
  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_YAW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PITCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_LIMIT = 2'd2;

  // Path state reported with every result beat.
  typedef struct packed {
    angle_t                  target_yaw;
    logic                    changed;
    logic [STEP_OUT_W-1:0]   step_index;
    logic                    done;
  } path_res_t;

  // Yaw change of a step; rows past the table or the path read as zero.
  function automatic angle_t rom_yaw(input int unsigned idx, input int unsigned steps);
    angle_t val;
    val = '0;
    if (idx < steps) begin
      case (idx)
        0: val = 18'sd0;
        1: val = 18'sd5120;
        2: val = 18'sd5120;
        3: val = 18'sd5120;
        4: val = -18'sd6400;
        5: val = -18'sd6400;
        6: val = -18'sd30720;
        default: val = '0;
      endcase
    end
    return val;
  endfunction

  // Pitch change of a step; rows past the table or the path read as zero.
  function automatic angle_t rom_pitch(input int unsigned idx, input int unsigned steps);
    angle_t val;
    val = '0;
    if (idx < steps) begin
      case (idx)
        1: val = -18'sd1536;
        3: val = -18'sd1536;
        5: val = -18'sd1536;
        default: val = '0;
      endcase
    end
    return val;
  endfunction

endpackage

// ----- hw/rtl/swseq_window.sv -----
// ============================================================================
// swseq_window
// Moving-average window of pitch samples: a shift line of the last
// WINDOW_LEN samples plus a running sum.
// ============================================================================
module swseq_window #(
  parameter int WINDOW_LEN = swseq_pkg::WINDOW_LEN_DEF,
  parameter int LOG_W      = $clog2(WINDOW_LEN),
  parameter int SUM_W      = swseq_pkg::PITCH_W + LOG_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start_en,
  input  logic                              sample_en,
  input  logic signed [swseq_pkg::PITCH_W-1:0] start_pitch,
  input  logic signed [swseq_pkg::PITCH_W-1:0] pitch,
  output logic signed [SUM_W-1:0]           sum_nxt,
  output logic signed [swseq_pkg::PITCH_W-1:0] average
);
  import swseq_pkg::*;

  pitch_t                  win_r [WINDOW_LEN];
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] pitch_ext;
  logic signed [SUM_W-1:0] oldest_ext;
  logic signed [SUM_W-1:0] start_ext;

  assign pitch_ext  = {{LOG_W{pitch[PITCH_W-1]}}, pitch};
  assign oldest_ext = {{LOG_W{win_r[WINDOW_LEN-1][PITCH_W-1]}}, win_r[WINDOW_LEN-1]};
  assign start_ext  = {{LOG_W{start_pitch[PITCH_W-1]}}, start_pitch};

  always_comb begin
    if (start_en) begin
      sum_nxt = start_ext <<< LOG_W;
    end else if (sample_en) begin
      sum_nxt = sum_r + pitch_ext - oldest_ext;
    end else begin
      sum_nxt = sum_r;
    end
  end

  // Arithmetic shift gives the floor of the mean.
  assign average = sum_nxt[SUM_W-1:LOG_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      sum_r <= sum_nxt;
      if (start_en) begin
        for (int i = 0; i < WINDOW_LEN; i++) begin
          win_r[i] <= start_pitch;
        end
      end else if (sample_en) begin
        win_r[0] <= pitch;
        for (int i = 1; i < WINDOW_LEN; i++) begin
          win_r[i] <= win_r[i-1];
        end
      end
    end
  end

endmodule

// ----- hw/rtl/swseq_path.sv -----
// ============================================================================
// swseq_path
// Dwell counter, step pointer, heading target and awaited pitch of the
// waypoint path.
// ============================================================================
module swseq_path #(
  parameter int WINDOW_LEN = swseq_pkg::WINDOW_LEN_DEF,
  parameter int PATH_STEPS = swseq_pkg::PATH_STEPS_DEF,
  parameter int LOG_W      = $clog2(WINDOW_LEN),
  parameter int SUM_W      = swseq_pkg::PITCH_W + LOG_W
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start_en,
  input  logic                                 sample_en,
  input  logic [swseq_pkg::TICK_W-1:0]         ticks,
  input  logic signed [SUM_W-1:0]              sum_nxt,
  input  logic signed [swseq_pkg::PITCH_W-1:0] start_yaw,
  input  logic signed [swseq_pkg::PITCH_W-1:0] start_pitch,
  input  logic [swseq_pkg::DWELL_W-1:0]        dwell_limit,
  output logic                                 finished,
  output swseq_pkg::path_res_t                 res_nxt
);
  import swseq_pkg::*;

  localparam int STEP_W = $clog2(PATH_STEPS + 1);
  localparam int DEV_W  = ANGLE_W + LOG_W + 1;
  localparam logic signed [DEV_W-1:0] BOUND = DEV_W'(ONE_DEG * WINDOW_LEN);

  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [STEP_W:0]    step_inc;
  angle_t             target_r, target_nxt;
  angle_t             awaited_r, awaited_nxt, awaited_adv;
  logic               expect_r, expect_nxt;
  logic               finished_r, finished_nxt;
  logic [DWELL_W-1:0] dwell_r, dwell_nxt, dwell_acc;
  logic [DWELL_W:0]   dwell_sum;
  logic               changed;
  logic               in_band;
  logic signed [DEV_W-1:0] dev;
  angle_t             start_yaw_ext, start_pitch_ext;
  logic [STEP_OUT_W+STEP_W-1:0] step_wide;

  assign start_yaw_ext   = {start_yaw[PITCH_W-1], start_yaw};
  assign start_pitch_ext = {start_pitch[PITCH_W-1], start_pitch};
  assign step_inc        = {1'b0, step_r} + 1'b1;

  assign dev = {{(DEV_W-SUM_W){sum_nxt[SUM_W-1]}}, sum_nxt}
             - ({{(DEV_W-ANGLE_W){awaited_r[ANGLE_W-1]}}, awaited_r} <<< LOG_W);
  assign in_band = (dev < BOUND) && (dev > -BOUND);

  assign dwell_sum   = {1'b0, dwell_r} + {{(DWELL_W+1-TICK_W){1'b0}}, ticks};
  assign dwell_acc   = dwell_sum[DWELL_W] ? '1 : dwell_sum[DWELL_W-1:0];
  assign awaited_adv = start_pitch_ext
                     + rom_pitch(32'(step_inc), 32'(PATH_STEPS));

  always_comb begin
    step_nxt     = step_r;
    target_nxt   = target_r;
    awaited_nxt  = awaited_r;
    expect_nxt   = expect_r;
    finished_nxt = finished_r;
    dwell_nxt    = dwell_r;
    changed      = 1'b0;
    if (start_en) begin
      step_nxt     = STEP_W'(1);
      target_nxt   = start_yaw_ext + rom_yaw(32'd0, 32'(PATH_STEPS));
      awaited_nxt  = start_pitch_ext + rom_pitch(32'd1, 32'(PATH_STEPS));
      expect_nxt   = rom_pitch(32'd1, 32'(PATH_STEPS)) != '0;
      finished_nxt = 1'b0;
      dwell_nxt    = '0;
    end else if (sample_en) begin
      dwell_nxt = (!expect_r || in_band) ? dwell_acc : '0;
      if (dwell_nxt > dwell_limit) begin
        dwell_nxt    = '0;
        target_nxt   = target_r + rom_yaw(32'(step_r), 32'(PATH_STEPS));
        step_nxt     = step_inc[STEP_W-1:0];
        awaited_nxt  = awaited_adv;
        expect_nxt   = awaited_adv != awaited_r;
        changed      = 1'b1;
        finished_nxt = step_inc >= (STEP_W+1)'(PATH_STEPS);
      end
    end
  end

  assign step_wide = {{STEP_OUT_W{1'b0}}, step_nxt};

  always_comb begin
    res_nxt.target_yaw = target_nxt;
    res_nxt.changed    = changed;
    res_nxt.step_index = step_wide[STEP_OUT_W-1:0];
    res_nxt.done       = finished_nxt;
  end

  assign finished = finished_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      target_r   <= '0;
      awaited_r  <= '0;
      expect_r   <= 1'b0;
      finished_r <= 1'b0;
      dwell_r    <= '0;
    end else begin
      step_r     <= step_nxt;
      target_r   <= target_nxt;
      awaited_r  <= awaited_nxt;
      expect_r   <= expect_nxt;
      finished_r <= finished_nxt;
      dwell_r    <= dwell_nxt;
    end
  end

endmodule

// ----- hw/rtl/slope_waypoint_sequencer.sv -----
// ============================================================================
// slope_waypoint_sequencer
// Follows a fixed waypoint path while climbing a slope, from pitch samples.
// ============================================================================
// Usage:
//   Input beats carry a request (start path or pitch sample), a pitch
//   sample and the ticks elapsed since the last sample. Every input beat
//   produces exactly one result beat with the heading target, a step-change
//   flag, the step pointer, the done flag and the moving-average pitch.
//   An input beat is taken into an input register and processed, once the
//   result register is free, into the result register, which drives the
//   output. One beat per cycle is sustained while the receiver does not
//   stall; the state update of one beat is seen by the next beat processed.
//   When the receiver stalls, the result register holds its beat and the
//   input side stalls once the input register is also occupied.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data
//   while no beat is in flight. Reset clears the window and path state,
//   zeroes start yaw and pitch, and sets the dwell limit to 1000.
// ============================================================================
module slope_waypoint_sequencer #(
  parameter int WINDOW_LEN = swseq_pkg::WINDOW_LEN_DEF,
  parameter int PATH_STEPS = swseq_pkg::PATH_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [swseq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swseq_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic signed [swseq_pkg::PITCH_W-1:0] in_pitch_sample,
  input  logic [swseq_pkg::TICK_W-1:0]         in_elapsed_ticks,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [swseq_pkg::ANGLE_W-1:0] out_target_yaw,
  output logic                                 out_target_changed,
  output logic [swseq_pkg::STEP_OUT_W-1:0]     out_step_index,
  output logic                                 out_path_done,
  output logic signed [swseq_pkg::PITCH_W-1:0] out_mean_pitch
);
  import swseq_pkg::*;

  localparam int LOG_W = $clog2(WINDOW_LEN);
  localparam int SUM_W = PITCH_W + LOG_W;

  pitch_t             start_yaw_r, start_pitch_r;
  logic [DWELL_W-1:0] dwell_limit_r;

  logic               in_v_r;
  logic               req_r;
  pitch_t             pitch_r;
  logic [TICK_W-1:0]  ticks_r;

  logic               out_v_r;
  path_res_t          res_r, res_nxt;
  pitch_t             avg_r, avg_nxt;

  logic               out_free, fire, finished;
  logic               start_en, sample_en;
  logic signed [SUM_W-1:0] sum_nxt;

  assign out_free  = !out_v_r || !out_stall;
  assign fire      = in_v_r && out_free;
  assign in_stall  = in_v_r && !out_free;
  assign start_en  = fire && (req_r == REQ_START);
  assign sample_en = fire && (req_r == REQ_SAMPLE) && !finished;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_yaw_r   <= '0;
      start_pitch_r <= '0;
      dwell_limit_r <= DWELL_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_YAW:   start_yaw_r   <= cfg_data;
        CFG_START_PITCH: start_pitch_r <= cfg_data;
        CFG_DWELL_LIMIT: dwell_limit_r <= cfg_data[DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r   <= in_req_type;
      pitch_r <= in_pitch_sample;
      ticks_r <= in_elapsed_ticks;
    end
  end

  swseq_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_en    (start_en),
    .sample_en   (sample_en),
    .start_pitch (start_pitch_r),
    .pitch       (pitch_r),
    .sum_nxt     (sum_nxt),
    .average     (avg_nxt)
  );

  swseq_path #(
    .WINDOW_LEN (WINDOW_LEN),
    .PATH_STEPS (PATH_STEPS)
  ) u_path (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_en    (start_en),
    .sample_en   (sample_en),
    .ticks       (ticks_r),
    .sum_nxt     (sum_nxt),
    .start_yaw   (start_yaw_r),
    .start_pitch (start_pitch_r),
    .dwell_limit (dwell_limit_r),
    .finished    (finished),
    .res_nxt     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
      avg_r <= avg_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_target_yaw     = res_r.target_yaw;
  assign out_target_changed = res_r.changed;
  assign out_step_index     = res_r.step_index;
  assign out_path_done      = res_r.done;
  assign out_mean_pitch     = avg_r;

endmodule

// ----- test/slope_waypoint_sequencer_checker.sv -----
// ----------------------------------------------------------------------------
// Slope waypoint sequencer checker
// Watches the configuration port and both beat channels, keeps its own model
// of the pitch window, dwell counter and path pointer, and compares every
// result beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
module slope_waypoint_sequencer_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [swseq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swseq_pkg::CFG_W-1:0]        cfg_data,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic                               in_req_type,
  input  swseq_pkg::pitch_t                  in_pitch_sample,
  input  logic [swseq_pkg::TICK_W-1:0]       in_elapsed_ticks,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  swseq_pkg::angle_t                  out_target_yaw,
  input  logic                               out_target_changed,
  input  logic [swseq_pkg::STEP_OUT_W-1:0]   out_step_index,
  input  logic                               out_path_done,
  input  swseq_pkg::pitch_t                  out_mean_pitch,
  output int unsigned                        fail_count,
  output int unsigned                        pending,
  output swseq_pkg::angle_t                  awaited_now,
  output logic                               done_now
);
  timeunit 1ns;
  timeprecision 1ps;
  import swseq_pkg::*;

  localparam int RING_LEN = WINDOW_LEN_DEF;
  localparam int PATH_LEN = PATH_STEPS_DEF;

  typedef struct packed {
    angle_t                target_yaw;
    logic                  changed;
    logic [STEP_OUT_W-1:0] step;
    logic                  done;
    pitch_t                avg;
  } path_report_t;

  // Configuration copy.
  pitch_t             base_yaw;
  pitch_t             base_pitch;
  logic [DWELL_W-1:0] dwell_limit;

  // Path state.
  pitch_t             pitch_ring [RING_LEN];
  logic signed [21:0] ring_sum;
  logic [2:0]         ring_slot;
  logic [DWELL_W-1:0] dwell;
  logic [3:0]         step_ptr;
  angle_t             heading;
  angle_t             awaited;
  logic               expect_shift;
  logic               finished;

  path_report_t expected_reports [$];

  function automatic angle_t yaw_turn(input logic [3:0] step);
    case (step)
      4'd1, 4'd2, 4'd3: return 18'sd5120;
      4'd4, 4'd5:       return -18'sd6400;
      4'd6:             return -18'sd30720;
      default:          return '0;
    endcase
  endfunction

  function automatic angle_t pitch_drop(input logic [3:0] step);
    case (step)
      4'd1, 4'd3, 4'd5: return -18'sd1536;
      default:          return '0;
    endcase
  endfunction

  task automatic predict_waypoint(input logic req, input pitch_t pitch,
                                  input logic [TICK_W-1:0] ticks,
                                  output path_report_t rep);
    logic signed [21:0] mean_full;
    logic [DWELL_W:0]   dwell_sum;
    angle_t             prev_awaited;
    int                 dev;
    int                 i;
    rep.changed = 1'b0;
    if (req == REQ_START) begin
      for (i = 0; i < RING_LEN; i++) pitch_ring[i] = base_pitch;
      ring_sum     = 22'(base_pitch) * RING_LEN;
      ring_slot    = '0;
      dwell        = '0;
      finished     = 1'b0;
      heading      = angle_t'(base_yaw) + yaw_turn(4'd0);
      step_ptr     = 4'd1;
      awaited      = angle_t'(base_pitch) + pitch_drop(step_ptr);
      expect_shift = (awaited != angle_t'(base_pitch));
    end else if (!finished) begin
      ring_sum              = ring_sum + pitch - pitch_ring[ring_slot];
      pitch_ring[ring_slot] = pitch;
      ring_slot             = ring_slot + 3'd1;

      dev = int'(ring_sum) - int'(awaited) * RING_LEN;
      if (dev < 0) dev = -dev;

      // The counter only runs while the average sits strictly inside one
      // degree of the awaited pitch, unless no pitch change is pending.
      if (!expect_shift || dev < ONE_DEG * RING_LEN) begin
        dwell_sum = {1'b0, dwell} + ticks;
        dwell     = dwell_sum[DWELL_W] ? '1 : dwell_sum[DWELL_W-1:0];
      end else begin
        dwell = '0;
      end

      if (dwell > dwell_limit) begin
        dwell        = '0;
        heading      = heading + yaw_turn(step_ptr);
        step_ptr     = step_ptr + 4'd1;
        prev_awaited = awaited;
        awaited      = angle_t'(base_pitch) + pitch_drop(step_ptr);
        expect_shift = (awaited != prev_awaited);
        rep.changed  = 1'b1;
        if (step_ptr >= PATH_LEN) finished = 1'b1;
      end
    end
    mean_full      = ring_sum >>> $clog2(RING_LEN);
    rep.target_yaw = heading;
    rep.step       = step_ptr[STEP_OUT_W-1:0];
    rep.done       = finished;
    rep.avg        = mean_full[PITCH_W-1:0];
  endtask

  always @(posedge clk) begin : watch
    path_report_t fresh;
    path_report_t want;
    logic         mismatch;
    int           i;
    if (!rst_n) begin
      base_yaw     = '0;
      base_pitch   = '0;
      dwell_limit  = DWELL_LIMIT_RST;
      for (i = 0; i < RING_LEN; i++) pitch_ring[i] = '0;
      ring_sum     = '0;
      ring_slot    = '0;
      dwell        = '0;
      step_ptr     = '0;
      heading      = '0;
      awaited      = '0;
      expect_shift = 1'b0;
      finished     = 1'b0;
      fail_count   = 0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_YAW:   base_yaw = cfg_data;
          CFG_START_PITCH: base_pitch = cfg_data;
          CFG_DWELL_LIMIT: dwell_limit = cfg_data[DWELL_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        predict_waypoint(in_req_type, in_pitch_sample, in_elapsed_ticks, fresh);
        expected_reports.push_back(fresh);
      end

      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: result beat with nothing pending, yaw %0d avg %0d",
                   $time, out_target_yaw, out_mean_pitch);
          fail_count++;
        end else begin
          want     = expected_reports.pop_front();
          mismatch = 1'b0;
          if (out_target_yaw !== want.target_yaw) begin
            $display("%0t: target_yaw expected %0d got %0d",
                     $time, want.target_yaw, out_target_yaw);
            mismatch = 1'b1;
          end
          if (out_target_changed !== want.changed) begin
            $display("%0t: target_changed expected %0b got %0b",
                     $time, want.changed, out_target_changed);
            mismatch = 1'b1;
          end
          if (out_step_index !== want.step) begin
            $display("%0t: step_index expected %0d got %0d",
                     $time, want.step, out_step_index);
            mismatch = 1'b1;
          end
          if (out_path_done !== want.done) begin
            $display("%0t: path_done expected %0b got %0b",
                     $time, want.done, out_path_done);
            mismatch = 1'b1;
          end
          if (out_mean_pitch !== want.avg) begin
            $display("%0t: mean_pitch expected %0d got %0d",
                     $time, want.avg, out_mean_pitch);
            mismatch = 1'b1;
          end
          if (mismatch) fail_count++;
        end
      end
    end
    pending     = expected_reports.size();
    awaited_now = awaited;
    done_now    = finished;
  end

endmodule

// ----- test/slope_waypoint_sequencer_test.sv -----
// ----------------------------------------------------------------------------
// Slope waypoint sequencer testbench
// Drives start commands and pitch samples in random bursts against a randomly
// stalling receiver. A short directed run covers samples before any start,
// the field extremes and the register extremes; the random run walks the
// path with samples aimed at the awaited pitch, mixed with restarts and noise,
// and a separate run drives the dwell counter into saturation once.
// ----------------------------------------------------------------------------
module slope_waypoint_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import swseq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int BEAT_TARGET = 950;
  localparam int PITCH_MAX   = 46080;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_req_type;
  pitch_t                in_pitch_sample;
  logic [TICK_W-1:0]     in_elapsed_ticks;
  logic                  out_valid;
  logic                  out_stall;
  angle_t                out_target_yaw;
  logic                  out_target_changed;
  logic [STEP_OUT_W-1:0] out_step_index;
  logic                  out_path_done;
  pitch_t                out_mean_pitch;

  int unsigned fail_count;
  int unsigned pending;
  angle_t      awaited_now;
  logic        done_now;

  int          burst_left = 0;
  int          beats_sent = 0;
  int          cycle_count = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;

  slope_waypoint_sequencer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_pitch_sample   (in_pitch_sample),
    .in_elapsed_ticks  (in_elapsed_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_target_yaw    (out_target_yaw),
    .out_target_changed(out_target_changed),
    .out_step_index    (out_step_index),
    .out_path_done     (out_path_done),
    .out_mean_pitch    (out_mean_pitch)
  );

  slope_waypoint_sequencer_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_pitch_sample   (in_pitch_sample),
    .in_elapsed_ticks  (in_elapsed_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_target_yaw    (out_target_yaw),
    .out_target_changed(out_target_changed),
    .out_step_index    (out_step_index),
    .out_path_done     (out_path_done),
    .out_mean_pitch    (out_mean_pitch),
    .fail_count        (fail_count),
    .pending           (pending),
    .awaited_now       (awaited_now),
    .done_now          (done_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("slope_waypoint_sequencer_test NOT OK");
      $finish;
    end
  end

  // The receiver switches at random between stall patterns.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(5, 60);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
      default:     out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic pitch_t random_pitch();
    case ($urandom_range(0, 9))
      0:       return pitch_t'(PITCH_MAX);
      1:       return pitch_t'(-PITCH_MAX);
      default: return pitch_t'(int'($urandom_range(0, 2 * PITCH_MAX)) - PITCH_MAX);
    endcase
  endfunction

  function automatic logic [TICK_W-1:0] random_ticks();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return TICK_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DWELL_W-1:0] random_limit();
    case ($urandom_range(0, 19))
      0, 1:    return '0;
      2:       return '1;
      default: return DWELL_W'($urandom_range(0, 500));
    endcase
  endfunction

  // A sample near the pitch the path is waiting for, kept inside the field range.
  function automatic pitch_t aimed_pitch(input int spread);
    int p;
    p = awaited_now + (int'($urandom_range(0, 2 * spread)) - spread);
    if (p > PITCH_MAX) p = PITCH_MAX;
    if (p < -PITCH_MAX) p = -PITCH_MAX;
    return pitch_t'(p);
  endfunction

  // Every task below starts and ends right after a falling edge.
  task automatic hold_off(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_beat(input logic req, input pitch_t pitch, input logic [TICK_W-1:0] ticks);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      hold_off($urandom_range(1, 6));
    end
    burst_left--;
    if (req == REQ_START || !done_now) beats_sent++;
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_pitch_sample  <= pitch;
    in_elapsed_ticks <= ticks;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic configure(input pitch_t yaw, input pitch_t pitch, input logic [DWELL_W-1:0] limit);
    settle();
    write_reg(CFG_START_YAW, yaw);
    write_reg(CFG_START_PITCH, pitch);
    write_reg(CFG_DWELL_LIMIT, {1'b0, limit});
    cfg_we <= 1'b0;
  endtask

  // A start followed by samples that mostly follow the awaited pitch, with the
  // odd restart, stray sample or full drain, then a few samples past the end.
  task automatic walk_path(input int max_beats);
    int n;
    send_beat(REQ_START, random_pitch(), random_ticks());
    for (n = 0; n < max_beats && !done_now; n++) begin
      case ($urandom_range(0, 39))
        0:       send_beat(REQ_START, random_pitch(), random_ticks());
        1, 2, 3: send_beat(REQ_SAMPLE, random_pitch(), random_ticks());
        4:       settle();
        default: send_beat(REQ_SAMPLE, aimed_pitch(($urandom_range(0, 7) == 0) ? 1500 : 120),
                           random_ticks());
      endcase
    end
    repeat ($urandom_range(1, 3)) send_beat(REQ_SAMPLE, random_pitch(), random_ticks());
  endtask

  task automatic run_noise(input int beats);
    repeat (beats) begin
      send_beat(($urandom_range(0, 9) == 0) ? REQ_START : REQ_SAMPLE, random_pitch(),
                random_ticks());
    end
  endtask

  // With the largest limit the counter pins at its maximum; lowering the
  // limit by one then lets a single tick advance the path.
  task automatic run_dwell_saturation();
    configure(pitch_t'(-PITCH_MAX), '0, '1);
    send_beat(REQ_START, random_pitch(), random_ticks());
    repeat (270) send_beat(REQ_SAMPLE, aimed_pitch(100), '1);
    configure(pitch_t'(-PITCH_MAX), '0, 16'hFFFE);
    send_beat(REQ_SAMPLE, aimed_pitch(100), 8'd1);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_START_YAW;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_req_type      = REQ_START;
    in_pitch_sample  = '0;
    in_elapsed_ticks = '0;
    out_stall        = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Samples before any start run on the reset state; the fourth one
    // crosses the default limit and advances from step zero.
    send_beat(REQ_SAMPLE, pitch_t'(PITCH_MAX), '1);
    send_beat(REQ_SAMPLE, pitch_t'(-PITCH_MAX), '1);
    send_beat(REQ_SAMPLE, '0, '1);
    send_beat(REQ_SAMPLE, pitch_t'(-1), '1);
    send_beat(REQ_SAMPLE, pitch_t'(1), '0);
    send_beat(REQ_START, pitch_t'(-1), '1);
    send_beat(REQ_SAMPLE, pitch_t'(PITCH_MAX), '0);

    configure(pitch_t'(PITCH_MAX), pitch_t'(PITCH_MAX), '0);
    send_beat(REQ_START, '0, '0);
    send_beat(REQ_SAMPLE, pitch_t'(PITCH_MAX), '1);
    send_beat(REQ_SAMPLE, aimed_pitch(0), 8'd1);

    configure(pitch_t'(-PITCH_MAX), pitch_t'(-PITCH_MAX), '1);
    send_beat(REQ_START, pitch_t'(PITCH_MAX), '1);
    send_beat(REQ_SAMPLE, pitch_t'(-PITCH_MAX), '1);
    send_beat(REQ_SAMPLE, pitch_t'(-PITCH_MAX), '1);
    send_beat(REQ_SAMPLE, pitch_t'(PITCH_MAX), '1);

    configure('0, '0, '0);
    send_beat(REQ_START, '0, '0);
    send_beat(REQ_SAMPLE, aimed_pitch(0), '1);
    send_beat(REQ_SAMPLE, aimed_pitch(0), '0);

    run_dwell_saturation();
    while (beats_sent < BEAT_TARGET) begin
      configure(random_pitch(), random_pitch(), random_limit());
      if ($urandom_range(0, 4) == 0) run_noise($urandom_range(10, 40));
      else walk_path(80);
    end

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("slope_waypoint_sequencer_test OK");
    else $display("slope_waypoint_sequencer_test NOT OK");
    $finish;
  end

endmodule
